/* hw/rtl/mpq_pkg.sv */
// Shared types and codes for the min priority queue.
// No dependencies; compiled before the interfaces and modules.
package mpq_pkg;

  localparam int COUNT_WIDTH = 11;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_TOP  = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       start;
    logic       out_free;
    logic [1:0] command;
  } ctl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [1:0] status;
  } stat_t;

endpackage

/* hw/rtl/mpq_if.sv */
// Request and result channel interfaces, valid/ready handshake.
// Depends on mpq_pkg.
interface mpq_in_if import mpq_pkg::*; #(parameter int KEY_WIDTH = 32) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [KEY_WIDTH-1:0] key_value;

  modport source(output valid, command, key_value, input ready);
  modport sink(input valid, command, key_value, output ready);
endinterface

interface mpq_out_if import mpq_pkg::*; #(parameter int KEY_WIDTH = 32) ();
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] top_value;
  logic                        queue_empty;
  logic [COUNT_WIDTH-1:0]      entry_count;
  logic [1:0]                  status;

  modport source(output valid, top_value, queue_empty, entry_count, status, input ready);
  modport sink(input valid, top_value, queue_empty, entry_count, status, output ready);
endinterface

/* hw/rtl/mpq_store.sv */
// Heap key memory: one write port, one read port with registered data.
// Depends on mpq_pkg.
module mpq_store import mpq_pkg::*; #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [KEY_WIDTH-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [KEY_WIDTH-1:0] rdata
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mpq_sift.sv */
// Sift sequencer: walks the heap one level at a time through the key memory
// with one shared signed comparator. Holds the entry count and root copy.
// Depends on mpq_pkg.
module mpq_sift import mpq_pkg::*; #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic [KEY_WIDTH-1:0] key_in,
  output stat_t                stat,
  output logic [CW-1:0]        count,
  output logic [KEY_WIDTH-1:0] top_key,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [KEY_WIDTH-1:0] wdata,
  output logic [AW-1:0]        raddr,
  input  logic [KEY_WIDTH-1:0] rdata
);

  localparam int XW = AW + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_P_CHK   = 3'd1;
  localparam logic [2:0] S_P_CMP   = 3'd2;
  localparam logic [2:0] S_POP_KEY = 3'd3;
  localparam logic [2:0] S_POP_CHK = 3'd4;
  localparam logic [2:0] S_POP_L   = 3'd5;
  localparam logic [2:0] S_POP_R   = 3'd6;
  localparam logic [2:0] S_POP_CMP = 3'd7;

  logic [2:0]           state;
  logic                 done_wait;
  logic [1:0]           status;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        cidx;
  logic [AW-1:0]        bidx;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] best;

  logic [CW-1:0]        cnt_m1;
  logic [AW-1:0]        pos_m1;
  logic [AW-1:0]        parent;
  logic [AW:0]          child;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        cidx_p1;
  logic                 child_ge;
  logic                 has_right;
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 lt;

  assign cnt_m1    = cnt - 1'b1;
  assign pos_m1    = pos - 1'b1;
  assign parent    = pos_m1 >> 1;
  assign child     = {pos, 1'b1};
  assign cnt_x     = XW'(cnt);
  assign cidx_p1   = XW'(cidx) + 1'b1;
  assign child_ge  = XW'(child) >= cnt_x;
  assign has_right = cidx_p1 < cnt_x;
  assign lt        = $signed(cmp_a) < $signed(cmp_b);

  assign stat.busy   = (state != S_IDLE) || done_wait;
  assign stat.done   = done_wait && ctl.out_free;
  assign stat.status = status;
  assign count       = cnt;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = key_q;
    raddr = cnt_m1[AW-1:0];
    cmp_a = key_q;
    cmp_b = rdata;
    case (state)
      S_P_CHK: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      S_P_CMP: begin
        we    = 1'b1;
        wdata = lt ? rdata : key_q;
      end
      S_POP_CHK: begin
        if (child_ge) begin
          we = (cnt != '0);
        end else begin
          raddr = child[AW-1:0];
        end
      end
      S_POP_L: begin
        raddr = cidx_p1[AW-1:0];
      end
      S_POP_R: begin
        cmp_a = rdata;
        cmp_b = best;
      end
      S_POP_CMP: begin
        cmp_a = best;
        cmp_b = key_q;
        we    = 1'b1;
        wdata = lt ? best : key_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      top_key <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_wait <= 1'b0;
      cnt       <= '0;
      status    <= ST_OK;
    end else begin
      if (stat.done) begin
        done_wait <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            key_q  <= key_in;
            status <= ST_OK;
            if (ctl.command == CMD_PUSH) begin
              if (cnt == CW'(CAPACITY)) begin
                status    <= ST_FULL;
                done_wait <= 1'b1;
              end else begin
                pos   <= cnt[AW-1:0];
                cnt   <= cnt + 1'b1;
                state <= S_P_CHK;
              end
            end else if (ctl.command == CMD_POP) begin
              if (cnt == '0) begin
                status    <= ST_EMPTY;
                done_wait <= 1'b1;
              end else begin
                cnt   <= cnt_m1;
                state <= S_POP_KEY;
              end
            end else begin
              if (cnt == '0) begin
                status <= ST_EMPTY;
              end
              done_wait <= 1'b1;
            end
          end
        end
        S_P_CHK: begin
          if (pos == '0) begin
            state     <= S_IDLE;
            done_wait <= 1'b1;
          end else begin
            state <= S_P_CMP;
          end
        end
        S_P_CMP: begin
          if (lt) begin
            pos   <= parent;
            state <= S_P_CHK;
          end else begin
            state     <= S_IDLE;
            done_wait <= 1'b1;
          end
        end
        S_POP_KEY: begin
          key_q <= rdata;
          pos   <= '0;
          state <= S_POP_CHK;
        end
        S_POP_CHK: begin
          if (child_ge) begin
            state     <= S_IDLE;
            done_wait <= 1'b1;
          end else begin
            cidx  <= child[AW-1:0];
            state <= S_POP_L;
          end
        end
        S_POP_L: begin
          best <= rdata;
          bidx <= cidx;
          state <= has_right ? S_POP_R : S_POP_CMP;
        end
        S_POP_R: begin
          if (lt) begin
            best <= rdata;
            bidx <= cidx_p1[AW-1:0];
          end
          state <= S_POP_CMP;
        end
        S_POP_CMP: begin
          if (lt) begin
            pos   <= bidx;
            state <= S_POP_CHK;
          end else begin
            state     <= S_IDLE;
            done_wait <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/min_priority_queue.sv */
// Min priority queue: binary heap in a key memory, one shared comparator.
// Top answers from the root copy; push places the key at the end and sifts it up toward
// the root, pop moves the last key to the root and sifts it down toward a leaf.
// One word in flight; a new word is taken once the result register is loaded.
// Synchronous reset empties the queue; key memory is not cleared.
module min_priority_queue import mpq_pkg::*; #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mpq_in_if.sink    request,
  mpq_out_if.source result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ctl_t                     ctl;
  stat_t                    stat;
  logic [CW-1:0]            count;
  logic [KEY_WIDTH-1:0]     top_key;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [KEY_WIDTH-1:0]     wdata;
  logic [AW-1:0]            raddr;
  logic [KEY_WIDTH-1:0]     rdata;
  logic [CW+COUNT_WIDTH-1:0] count_ext;

  assign request.ready = !stat.busy;
  assign ctl.start     = request.valid && !stat.busy;
  assign ctl.command   = request.command;
  assign ctl.out_free  = !result.valid || result.ready;
  assign count_ext     = {{COUNT_WIDTH{1'b0}}, count};

  mpq_store #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mpq_sift #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_sift (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .key_in  (request.key_value),
    .stat    (stat),
    .count   (count),
    .top_key (top_key),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (stat.done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      result.top_value   <= (count == '0) ? '0 : top_key;
      result.queue_empty <= (count == '0);
      result.entry_count <= count_ext[COUNT_WIDTH-1:0];
      result.status      <= stat.status;
    end
  end

endmodule

/* bench/tb.sv */
// Testbench for min_priority_queue: random and directed push/top/pop/spare words with a
// scoreboard that tracks the live keys and checks every result word in order.
// Depends on mpq_pkg, mpq_in_if/mpq_out_if and the min_priority_queue RTL.
module tb;
  import mpq_pkg::*;

  localparam int CAPACITY    = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  // unused code, behaves as top
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

  typedef struct {
    logic signed [KEY_WIDTH-1:0] top_value;
    logic                        queue_empty;
    logic [COUNT_WIDTH-1:0]      entry_count;
    logic [1:0]                  status;
  } outcome_t;

  class queue_scoreboard;
    logic signed [KEY_WIDTH-1:0] keys[$];
    outcome_t                    waiting[$];
    int                          errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function int live();
      return keys.size();
    endfunction

    function int smallest_index();
      int idx;
      idx = 0;
      for (int i = 1; i < keys.size(); i++)
        if (keys[i] < keys[idx]) idx = i;
      return idx;
    endfunction

    function void note_request(logic [1:0] cmd, logic signed [KEY_WIDTH-1:0] key);
      outcome_t o;
      o.status = ST_OK;
      if (cmd == CMD_PUSH) begin
        if (keys.size() >= CAPACITY) o.status = ST_FULL;
        else keys.push_back(key);
      end else if (keys.size() == 0) begin
        o.status = ST_EMPTY;
      end else if (cmd == CMD_POP) begin
        keys.delete(smallest_index());
      end
      o.top_value   = (keys.size() > 0) ? keys[smallest_index()] : '0;
      o.queue_empty = (keys.size() == 0);
      o.entry_count = COUNT_WIDTH'(keys.size());
      waiting.push_back(o);
    endfunction

    function void check_result(logic signed [KEY_WIDTH-1:0] top_value, logic queue_empty,
                               logic [COUNT_WIDTH-1:0] entry_count, logic [1:0] status);
      outcome_t o;
      if (waiting.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      o = waiting.pop_front();
      if (top_value !== o.top_value) begin
        $error("top_value: expected %0d, got %0d", o.top_value, top_value);
        errors++;
      end
      if (queue_empty !== o.queue_empty) begin
        $error("queue_empty: expected %0d, got %0d", o.queue_empty, queue_empty);
        errors++;
      end
      if (entry_count !== o.entry_count) begin
        $error("entry_count: expected %0d, got %0d", o.entry_count, entry_count);
        errors++;
      end
      if (status !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   stall_cycles;
  int   send_run;
  queue_scoreboard sb;

  mpq_in_if  #(.KEY_WIDTH(KEY_WIDTH)) req_if ();
  mpq_out_if #(.KEY_WIDTH(KEY_WIDTH)) res_if ();

  min_priority_queue #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .request(req_if.sink),
    .result (res_if.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_PUSH;
    req_if.key_value <= '0;
    res_if.ready     <= 1'b0;
  end

  // idle cycles before a word; occasional back-to-back runs
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] rand_key();
    case ($urandom_range(0, 9))
      6, 7:    return $signed($urandom_range(0, 16)) - 8;
      8:       return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      9:       return KEY_MIN + $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic signed [KEY_WIDTH-1:0] key);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.key_value <= key;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(cmd, key);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_mix(input int words, input int w_push, input int w_pop,
                          input int w_top);
    int pick;
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, w_push + w_pop + w_top);
      if (pick < w_push) send_word(CMD_PUSH, rand_key());
      else if (pick < w_push + w_pop) send_word(CMD_POP, $urandom);
      else if (pick < w_push + w_pop + w_top) send_word(CMD_TOP, $urandom);
      else send_word(CMD_SPARE, $urandom);
    end
  endtask

  task automatic fill_to_capacity();
    int drops;
    drops = 0;
    while (sb.live() < CAPACITY || drops < 6) begin
      if ($urandom_range(0, 39) == 0) begin
        send_word($urandom_range(0, 3) == 0 ? CMD_SPARE : CMD_TOP, $urandom);
      end else begin
        if (sb.live() >= CAPACITY) drops++;
        send_word(CMD_PUSH, rand_key());
      end
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    send_run = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_TOP, $urandom);
    send_word(CMD_POP, $urandom);
    send_word(CMD_SPARE, $urandom);
    send_word(CMD_PUSH, '0);
    send_word(CMD_PUSH, KEY_MAX);
    send_word(CMD_PUSH, KEY_MIN);
    send_word(CMD_TOP, KEY_MIN);
    send_word(CMD_SPARE, KEY_MAX);
    send_word(CMD_PUSH, -1);
    send_word(CMD_PUSH, -1);
    send_word(CMD_PUSH, 1);
    repeat (3) send_word(CMD_POP, $urandom);
    send_word(CMD_PUSH, KEY_MAX);
    repeat (4) send_word(CMD_POP, $urandom);
    send_word(CMD_POP, KEY_MAX);
    send_word(CMD_TOP, '0);

    send_mix(20, 45, 40, 10);
    wait_drained();
    fill_to_capacity();
    wait_drained();
    send_mix(30, 25, 60, 15);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // result side
  initial begin
    int gap;
    int run;
    int seen;
    run = 0;
    seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(run);
      if (seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      sb.check_result(res_if.top_value, res_if.queue_empty, res_if.entry_count,
                      res_if.status);
      seen++;
    end
  end

  // watchdog
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* min_priority_queue.f */
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_if.sv
hw/rtl/mpq_store.sv
hw/rtl/mpq_sift.sv
hw/rtl/min_priority_queue.sv
bench/tb.sv
